// File: design/hcc_pkg.sv
package hcc_pkg;

    localparam int TableWidth  = 36;
    localparam int EnableWidth = 6;
    localparam int DutyWidth   = 7;
    localparam int TickWidth   = 32;
    localparam int LevelWidth  = 11;
    localparam int HallWidth   = 3;
    localparam int CfgIdxWidth = 1;

    localparam logic [DutyWidth-1:0]         DutyMax      = 7'd90;
    localparam logic signed [LevelWidth-1:0] DeadBand     = 11'sd10;
    // |level| at or above this saturates the duty
    localparam logic [LevelWidth-1:0]        DutySatLevel = 11'd900;
    // x / 10 == (x * 205) >> 11 for x below 900
    localparam logic [7:0]                   DivTenMul    = 8'd205;
    localparam int                           DivTenShift  = 11;

    localparam logic [CfgIdxWidth-1:0] CFG_FORWARD_TABLE = 1'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_REVERSE_TABLE = 1'd1;

    typedef enum logic [1:0] {
        CMD_HALL_EDGE    = 2'd0,
        CMD_DRIVE_UPDATE = 2'd1,
        CMD_RESYNC       = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef struct packed {
        logic signed [TickWidth-1:0] tick_total;
        logic [2:0]                  last_sector;
        dir_t                        rotation_dir;
        logic                        resync_pending;
        logic [DutyWidth-1:0]        duty_value;
        logic [EnableWidth-1:0]      bridge_state;
    } state_t;

    function automatic logic [2:0] hall_sector(input logic [HallWidth-1:0] hall);
        logic [2:0] sector;
        case (hall)
            3'd1:    sector = 3'd0;
            3'd2:    sector = 3'd2;
            3'd3:    sector = 3'd1;
            3'd4:    sector = 3'd4;
            3'd5:    sector = 3'd5;
            3'd6:    sector = 3'd3;
            default: sector = 3'd0;
        endcase
        return sector;
    endfunction

endpackage

// File: design/hcc_cfg.sv
module hcc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [hcc_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [hcc_pkg::TableWidth-1:0]      cfg_data,
    output logic [hcc_pkg::TableWidth-1:0]      forward_table,
    output logic [hcc_pkg::TableWidth-1:0]      reverse_table
);

    logic [hcc_pkg::TableWidth-1:0] fwd_reg;
    logic [hcc_pkg::TableWidth-1:0] rev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rev_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hcc_pkg::CFG_FORWARD_TABLE: fwd_reg <= cfg_data;
                hcc_pkg::CFG_REVERSE_TABLE: rev_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign forward_table = fwd_reg;
    assign reverse_table = rev_reg;

endmodule

// File: design/hcc_step.sv
module hcc_step
(
    input  hcc_pkg::state_t                        state_cur,
    input  logic [1:0]                             cmd,
    input  logic [hcc_pkg::HallWidth-1:0]          hall_word,
    input  logic signed [hcc_pkg::LevelWidth-1:0]  drive_level,
    input  logic [hcc_pkg::TableWidth-1:0]         forward_table,
    input  logic [hcc_pkg::TableWidth-1:0]         reverse_table,
    output hcc_pkg::state_t                        state_next,
    output logic                                   hall_fault
);

    function automatic logic [hcc_pkg::EnableWidth-1:0] table_entry(
        input logic [hcc_pkg::TableWidth-1:0] tbl,
        input logic [hcc_pkg::HallWidth-1:0]  hall
    );
        logic [hcc_pkg::EnableWidth-1:0] entry;
        case (hall)
            3'd1:    entry = tbl[5:0];
            3'd2:    entry = tbl[11:6];
            3'd3:    entry = tbl[17:12];
            3'd4:    entry = tbl[23:18];
            3'd5:    entry = tbl[29:24];
            3'd6:    entry = tbl[35:30];
            default: entry = '0;
        endcase
        return entry;
    endfunction

    logic                                   hall_ok;
    logic [2:0]                             sector;
    logic signed [3:0]                      delta_raw;
    logic signed [3:0]                      delta;
    hcc_pkg::state_t                        hs_state;
    logic [hcc_pkg::LevelWidth-1:0]         level_mag;
    logic [18:0]                            div_prod;
    logic [hcc_pkg::DutyWidth-1:0]          duty_calc;
    hcc_pkg::dir_t                          dir_calc;

    // hall step on the current state
    always_comb
    begin
        hall_ok   = (hall_word != 3'd0) && (hall_word != 3'd7);
        sector    = hcc_pkg::hall_sector(hall_word);
        delta_raw = $signed({1'b0, sector}) - $signed({1'b0, state_cur.last_sector});
        if (delta_raw <= -4'sd3)
            delta = delta_raw + 4'sd6;
        else if (delta_raw >= 4'sd3)
            delta = delta_raw - 4'sd6;
        else
            delta = delta_raw;

        hs_state = state_cur;
        if (hall_ok)
        begin
            hs_state.tick_total  = state_cur.tick_total
                                 + {{(hcc_pkg::TickWidth-4){delta[3]}}, delta};
            hs_state.last_sector = sector;
        end
        case (state_cur.rotation_dir)
            hcc_pkg::DIR_FWD:
                hs_state.bridge_state = hall_ok ? table_entry(forward_table, hall_word) : '0;
            hcc_pkg::DIR_REV:
                hs_state.bridge_state = hall_ok ? table_entry(reverse_table, hall_word) : '0;
            default:
            begin
                hs_state.bridge_state   = '0;
                hs_state.resync_pending = 1'b1;
            end
        endcase
    end

    // direction and duty from the drive level
    always_comb
    begin
        level_mag = drive_level[hcc_pkg::LevelWidth-1]
                  ? hcc_pkg::LevelWidth'(-drive_level)
                  : hcc_pkg::LevelWidth'(drive_level);
        div_prod  = level_mag * hcc_pkg::DivTenMul;
        if (level_mag >= hcc_pkg::DutySatLevel)
            duty_calc = hcc_pkg::DutyMax;
        else
            duty_calc = div_prod[hcc_pkg::DivTenShift +: hcc_pkg::DutyWidth];

        if (drive_level > hcc_pkg::DeadBand)
            dir_calc = hcc_pkg::DIR_FWD;
        else if (drive_level < -hcc_pkg::DeadBand)
            dir_calc = hcc_pkg::DIR_REV;
        else
            dir_calc = hcc_pkg::DIR_NONE;
    end

    always_comb
    begin
        state_next = state_cur;
        hall_fault = 1'b0;
        case (cmd)
            hcc_pkg::CMD_HALL_EDGE:
            begin
                state_next = hs_state;
                hall_fault = !hall_ok;
            end
            hcc_pkg::CMD_DRIVE_UPDATE:
            begin
                if (state_cur.resync_pending)
                begin
                    state_next = hs_state;
                    hall_fault = !hall_ok;
                end
                state_next.resync_pending = 1'b0;
                state_next.rotation_dir   = dir_calc;
                state_next.duty_value     = duty_calc;
            end
            hcc_pkg::CMD_RESYNC:
                state_next.resync_pending = 1'b1;
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/hall_commutation_tick_counter.sv
// Six-step commutation with a hall position counter. Each input beat carries a
// command (hall edge, drive update, resync request) and the hall word and drive
// level; each beat returns exactly one output beat with the bridge enables, duty,
// tick count, direction and the hall fault of that beat. One beat is taken every
// clock unless the output stalls. A beat is captured in the input register at its
// accepting edge and the step logic writes the result register when that beat
// advances. The result register carries the state update so the following beat
// sees it at once. While the output is not taken the input register keeps its beat
// and the input stalls. The user must write the gate tables through the cfg port,
// which is always ready, only while no beat is in flight; it is not enforced.
module hall_commutation_tick_counter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // hall_word, drive_level
    input  logic [1:0]                          s_tuser,  // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bridge_enables, duty_percent, tick_count, direction, hall_fault
    output logic [47:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hcc_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [hcc_pkg::TableWidth-1:0]      cfg_data
);

    logic                                       in_valid_reg;
    logic [1:0]                                 in_cmd_reg;
    logic [hcc_pkg::HallWidth-1:0]              in_hall_reg;
    logic signed [hcc_pkg::LevelWidth-1:0]      in_level_reg;
    logic                                       out_valid_reg;
    logic                                       out_fault_reg;
    hcc_pkg::state_t                            state_reg;
    hcc_pkg::state_t                            state_next;
    logic                                       fault_next;
    logic                                       advance;
    logic [hcc_pkg::TableWidth-1:0]             forward_table;
    logic [hcc_pkg::TableWidth-1:0]             reverse_table;

    hcc_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .forward_table (forward_table),
        .reverse_table (reverse_table)
    );

    hcc_step u_step
    (
        .state_cur     (state_reg),
        .cmd           (in_cmd_reg),
        .hall_word     (in_hall_reg),
        .drive_level   (in_level_reg),
        .forward_table (forward_table),
        .reverse_table (reverse_table),
        .state_next    (state_next),
        .hall_fault    (fault_next)
    );

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= s_tuser;
            in_hall_reg  <= s_tdata[2:0];
            in_level_reg <= s_tdata[13:3];
        end
    end

    // the state doubles as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg            <= 1'b0;
            state_reg.tick_total     <= '0;
            state_reg.last_sector    <= '0;
            state_reg.rotation_dir   <= hcc_pkg::DIR_NONE;
            state_reg.resync_pending <= 1'b1;
            state_reg.duty_value     <= '0;
            state_reg.bridge_state   <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            state_reg     <= state_next;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_fault_reg <= fault_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_fault_reg,
                       state_reg.rotation_dir,
                       state_reg.tick_total,
                       state_reg.duty_value,
                       state_reg.bridge_state};

    a_duty_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.duty_value <= hcc_pkg::DutyMax)
        else $error("duty above saturation limit");

    a_fault_bridge_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_fault_reg) |-> (state_reg.bridge_state == '0))
        else $error("hall fault with bridge enabled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without backpressure");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after step");

endmodule
